>>> rtl/lobm_pkg.sv
package lobm_pkg;

    localparam int SideDepth = 16;

    typedef enum logic [2:0] {
        K_TRADE     = 3'd0,
        K_EXPIRED   = 3'd1,
        K_CANCELLED = 3'd2,
        K_RESTED    = 3'd3,
        K_CLOSED    = 3'd4,
        K_FULL      = 3'd5,
        K_DONE      = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        C_ADD    = 2'd0,
        C_CANCEL = 2'd1,
        C_SWEEP  = 2'd2,
        C_RSVD   = 2'd3
    } t_cmd;

    // datapath table operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_REMOVE = 3'd1,
        OP_SETQTY = 3'd2,
        OP_INSERT = 3'd3,
        OP_LOAD   = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        side;
        logic [4:0]  idx;
        logic [30:0] qty;
    } t_dp_cmd;

    typedef struct packed {
        logic [31:0] price;
        logic [30:0] qty;
        logic [31:0] id;
        logic [31:0] expiry;
    } t_entry;

endpackage

>>> rtl/limit_order_book_matcher.sv
// Price-time priority order matcher with a bid table and an ask table.
// Input channel (i_valid / o_stall): one command per transfer: add, cancel
// by id, or expiry sweep. o_stall rises after the transfer and stays high
// until the command's done report has been loaded into the output register.
// Output channel (o_valid / i_stall): a stream of reports per command,
// expired entries first, then trades, closed, rested, side full or
// cancelled reports, then a done report with o_last set.
// Timing: the controller looks at one table entry per cycle, except where
// a report waits for the output register. Each command first sweeps the
// bid and then the ask table for expired entries; an add then walks the
// opposite table to match, decides on resting and walks its own table for
// the insert position; a cancel walks the bid and then the ask table. Every
// removal, fill or insert adds a settle slot; accept and done are steps of
// their own. Each side holds 16 entries; reads share one entry read port.
// A new command is taken only after the previous one finished; the last
// report may still wait in the output register.
// Reset empties both tables (counts cleared, entries left as they are).
// While i_stall is high the output report holds and the sequencer waits at
// its next report.
module limit_order_book_matcher #(
    parameter int SIDE_DEPTH = lobm_pkg::SideDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic        i_side,
    input  logic        i_is_market,
    input  logic [31:0] i_price,
    input  logic [30:0] i_quantity,
    input  logic [31:0] i_order_id,
    input  logic [31:0] i_expiry_time,
    input  logic [31:0] i_now_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic        o_report_side,
    output logic [31:0] o_report_id,
    output logic [31:0] o_maker_id,
    output logic [31:0] o_report_price,
    output logic [30:0] o_report_qty,
    output logic        o_last
);
    localparam int CW = $clog2(SIDE_DEPTH + 1);

    lobm_pkg::t_dp_cmd w_dp;
    lobm_pkg::t_entry  w_new;
    lobm_pkg::t_entry  w_rd;
    logic              w_rside;
    logic [CW-1:0]     w_ridx;
    logic [CW-1:0]     w_bid_count;
    logic [CW-1:0]     w_ask_count;

    lobm_ctrl #(.DEPTH(SIDE_DEPTH), .CW(CW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_side(i_side), .i_is_market(i_is_market),
        .i_price(i_price), .i_quantity(i_quantity), .i_order_id(i_order_id),
        .i_expiry_time(i_expiry_time), .i_now_time(i_now_time),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_report_side(o_report_side),
        .o_report_id(o_report_id), .o_maker_id(o_maker_id),
        .o_report_price(o_report_price), .o_report_qty(o_report_qty),
        .o_last(o_last),
        .o_dp(w_dp), .o_new(w_new), .o_rside(w_rside), .o_ridx(w_ridx),
        .i_rd(w_rd), .i_bid_count(w_bid_count), .i_ask_count(w_ask_count)
    );

    lobm_datapath #(.DEPTH(SIDE_DEPTH), .CW(CW)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_dp), .i_new(w_new),
        .i_rside(w_rside), .i_ridx(w_ridx), .o_rd(w_rd),
        .o_bid_count(w_bid_count), .o_ask_count(w_ask_count)
    );
endmodule

>>> rtl/lobm_table.sv
module lobm_table #(
    parameter int DEPTH = lobm_pkg::SideDepth,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lobm_pkg::t_dp_cmd i_cmd,
    input  logic              i_sel,
    input  lobm_pkg::t_entry  i_new,
    input  logic [CW-1:0]     i_ridx,
    output lobm_pkg::t_entry  o_rd,
    output logic [CW-1:0]     o_count
);
    localparam int IW = $clog2(DEPTH);

    lobm_pkg::t_entry r_ent [DEPTH];
    lobm_pkg::t_entry n_ent [DEPTH];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [IW-1:0]    w_ridx;
    logic [CW-1:0]    w_cidx;

    assign w_cidx  = i_cmd.idx[CW-1:0];
    assign w_ridx  = i_ridx[IW-1:0];
    assign o_rd    = r_ent[w_ridx];
    assign o_count = r_count;

    // shift network for remove and insert; set-qty rewrites one quantity
    always_comb begin
        n_count = r_count;
        for (int j = 0; j < DEPTH; j++) begin
            n_ent[j] = r_ent[j];
        end
        if (i_sel) begin
            case (i_cmd.op)
                lobm_pkg::OP_REMOVE: begin
                    for (int j = 0; j < DEPTH - 1; j++) begin
                        if (CW'(j) >= w_cidx) begin
                            n_ent[j] = r_ent[j+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end
                lobm_pkg::OP_SETQTY: begin
                    n_ent[w_cidx[IW-1:0]].qty = i_cmd.qty;
                end
                lobm_pkg::OP_INSERT: begin
                    for (int j = 1; j < DEPTH; j++) begin
                        if (CW'(j) > w_cidx) begin
                            n_ent[j] = r_ent[j-1];
                        end
                    end
                    n_ent[w_cidx[IW-1:0]] = i_new;
                    n_count = r_count + CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DEPTH; j++) begin
            r_ent[j] <= n_ent[j];
        end
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end
endmodule

>>> rtl/lobm_datapath.sv
module lobm_datapath #(
    parameter int DEPTH = lobm_pkg::SideDepth,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lobm_pkg::t_dp_cmd i_cmd,
    input  lobm_pkg::t_entry  i_new,
    input  logic              i_rside,
    input  logic [CW-1:0]     i_ridx,
    output lobm_pkg::t_entry  o_rd,
    output logic [CW-1:0]     o_bid_count,
    output logic [CW-1:0]     o_ask_count
);
    lobm_pkg::t_entry w_bid_rd;
    lobm_pkg::t_entry w_ask_rd;

    lobm_table #(.DEPTH(DEPTH), .CW(CW)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd), .i_sel(!i_cmd.side),
        .i_new(i_new), .i_ridx(i_ridx), .o_rd(w_bid_rd), .o_count(o_bid_count)
    );

    lobm_table #(.DEPTH(DEPTH), .CW(CW)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd), .i_sel(i_cmd.side),
        .i_new(i_new), .i_ridx(i_ridx), .o_rd(w_ask_rd), .o_count(o_ask_count)
    );

    assign o_rd = i_rside ? w_ask_rd : w_bid_rd;
endmodule

>>> rtl/lobm_ctrl.sv
module lobm_ctrl #(
    parameter int DEPTH = lobm_pkg::SideDepth,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_cmd,
    input  logic              i_side,
    input  logic              i_is_market,
    input  logic [31:0]       i_price,
    input  logic [30:0]       i_quantity,
    input  logic [31:0]       i_order_id,
    input  logic [31:0]       i_expiry_time,
    input  logic [31:0]       i_now_time,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_kind,
    output logic              o_report_side,
    output logic [31:0]       o_report_id,
    output logic [31:0]       o_maker_id,
    output logic [31:0]       o_report_price,
    output logic [30:0]       o_report_qty,
    output logic              o_last,
    output lobm_pkg::t_dp_cmd o_dp,
    output lobm_pkg::t_entry  o_new,
    output logic              o_rside,
    output logic [CW-1:0]     o_ridx,
    input  lobm_pkg::t_entry  i_rd,
    input  logic [CW-1:0]     i_bid_count,
    input  logic [CW-1:0]     i_ask_count
);
    typedef enum logic [2:0] {
        S_IDLE, S_EXP, S_MATCH, S_POS, S_FINAL, S_CANCEL, S_DONE, S_OUT
    } t_state;

    t_state        r_state, r_ret;
    logic [1:0]    r_cmd;
    logic          r_side, r_mkt;
    logic [31:0]   r_price, r_id, r_exp, r_now;
    logic [30:0]   r_qty;
    logic          r_s;
    logic [CW-1:0] r_i;
    logic          r_ov;
    logic [2:0]    r_kind;
    logic          r_rs, r_last;
    logic [31:0]   r_rid, r_mid, r_rp;
    logic [30:0]   r_rq;
    lobm_pkg::t_dp_cmd r_dp;

    logic [CW-1:0] w_cnt;
    logic          w_cross;
    logic [30:0]   w_tq;
    logic          w_out_free;
    logic          w_emit;
    logic          w_load;

    assign w_cnt      = r_s ? i_ask_count : i_bid_count;
    assign w_cross    = r_mkt || (r_side ? (r_price <= i_rd.price)
                                         : (r_price >= i_rd.price));
    assign w_tq       = (r_qty < i_rd.qty) ? r_qty : i_rd.qty;
    assign w_out_free = !r_ov || !i_stall;

    assign o_stall        = r_state != S_IDLE;
    assign o_valid        = r_ov;
    assign o_kind         = r_kind;
    assign o_report_side  = r_rs;
    assign o_report_id    = r_rid;
    assign o_maker_id     = r_mid;
    assign o_report_price = r_rp;
    assign o_report_qty   = r_rq;
    assign o_last         = r_last;
    assign o_rside        = r_s;
    assign o_ridx         = r_i;
    assign o_new          = '{price: r_price, qty: r_qty, id: r_id, expiry: r_exp};

    // table operation is applied during the settle slot only
    assign o_dp = '{op: (r_state == S_OUT) ? r_dp.op : lobm_pkg::OP_NONE,
                    side: r_dp.side, idx: r_dp.idx, qty: r_dp.qty};

    // current step has a report to load
    always_comb begin
        case (r_state)
            S_EXP:    w_emit = (r_i < w_cnt) && (i_rd.expiry <= r_now);
            S_MATCH:  w_emit = (r_qty != '0) && (r_i < w_cnt) && w_cross
                               && (w_tq != '0);
            S_FINAL:  w_emit = r_mkt || (r_qty == '0)
                               || ((r_side ? i_ask_count : i_bid_count) >= CW'(DEPTH));
            S_POS:    w_emit = (r_i >= w_cnt) || (r_side ? (r_price < i_rd.price)
                                                        : (r_price > i_rd.price));
            S_CANCEL: w_emit = (r_i < w_cnt) && (i_rd.id == r_id);
            S_DONE:   w_emit = 1'b1;
            default:  w_emit = 1'b0;
        endcase
    end

    assign w_load = w_emit && w_out_free;

    // sequencer: one entry per cycle, held on output stalls and settle slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_ret   <= S_IDLE;
        end else begin
            r_ov <= w_load || (r_ov && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_side  <= i_side;
                        r_mkt   <= i_is_market;
                        r_price <= i_price;
                        r_qty   <= i_quantity;
                        r_id    <= i_order_id;
                        r_exp   <= i_expiry_time;
                        r_now   <= i_now_time;
                        r_s     <= 1'b0;
                        r_i     <= '0;
                        r_state <= S_EXP;
                    end
                end
                // a wait slot after each table change lets the shift settle
                S_OUT: begin
                    r_state <= r_ret;
                end
                S_EXP: begin
                    if (r_i >= w_cnt) begin
                        if (r_s) begin
                            r_i <= '0;
                            if (r_cmd == lobm_pkg::C_ADD) begin
                                r_s     <= !r_side;
                                r_state <= S_MATCH;
                            end else if (r_cmd == lobm_pkg::C_CANCEL) begin
                                r_s     <= 1'b0;
                                r_state <= S_CANCEL;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_s <= 1'b1;
                            r_i <= '0;
                        end
                    end else if (i_rd.expiry <= r_now) begin
                        if (w_out_free) begin
                            r_kind <= lobm_pkg::K_EXPIRED;
                            r_rs <= r_s; r_rid <= i_rd.id; r_mid <= '0;
                            r_rp <= i_rd.price; r_rq <= i_rd.qty; r_last <= 1'b0;
                            r_dp <= '{op: lobm_pkg::OP_REMOVE, side: r_s,
                                      idx: 5'(r_i), qty: '0};
                            r_ret <= S_EXP; r_state <= S_OUT;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_MATCH: begin
                    if (r_qty == '0 || r_i >= w_cnt || !w_cross) begin
                        r_state <= S_FINAL;
                    end else if (w_tq == '0) begin
                        r_i <= r_i + CW'(1);
                    end else if (w_out_free) begin
                        r_kind <= lobm_pkg::K_TRADE;
                        r_rs <= r_side; r_rid <= r_id; r_mid <= i_rd.id;
                        r_rp <= i_rd.price; r_rq <= w_tq; r_last <= 1'b0;
                        r_qty <= r_qty - w_tq;
                        if (i_rd.qty == w_tq) begin
                            r_dp <= '{op: lobm_pkg::OP_REMOVE, side: r_s,
                                      idx: 5'(r_i), qty: '0};
                        end else begin
                            r_dp <= '{op: lobm_pkg::OP_SETQTY, side: r_s,
                                      idx: 5'(r_i), qty: i_rd.qty - w_tq};
                            r_i <= r_i + CW'(1);
                        end
                        r_ret <= S_MATCH; r_state <= S_OUT;
                    end
                end
                S_FINAL: begin
                    r_s <= r_side;
                    r_i <= '0;
                    if (r_mkt || r_qty == '0) begin
                        if (w_out_free) begin
                            r_kind <= lobm_pkg::K_CLOSED;
                            r_rs <= r_side; r_rid <= r_id; r_mid <= '0;
                            r_rp <= r_price; r_rq <= r_qty; r_last <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end else if ((r_side ? i_ask_count : i_bid_count) >= CW'(DEPTH)) begin
                        if (w_out_free) begin
                            r_kind <= lobm_pkg::K_FULL;
                            r_rs <= r_side; r_rid <= r_id; r_mid <= '0;
                            r_rp <= r_price; r_rq <= r_qty; r_last <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_POS;
                    end
                end
                // scan own side for the insert position
                S_POS: begin
                    if (r_i >= w_cnt || (r_side ? (r_price < i_rd.price)
                                               : (r_price > i_rd.price))) begin
                        if (w_out_free) begin
                            r_kind <= lobm_pkg::K_RESTED;
                            r_rs <= r_side; r_rid <= r_id; r_mid <= '0;
                            r_rp <= r_price; r_rq <= r_qty; r_last <= 1'b0;
                            r_dp <= '{op: lobm_pkg::OP_INSERT, side: r_side,
                                      idx: 5'(r_i), qty: r_qty};
                            r_ret <= S_DONE; r_state <= S_OUT;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_CANCEL: begin
                    if (r_i >= w_cnt) begin
                        if (r_s) begin
                            r_state <= S_DONE;
                        end else begin
                            r_s <= 1'b1;
                            r_i <= '0;
                        end
                    end else if (i_rd.id == r_id) begin
                        if (w_out_free) begin
                            r_kind <= lobm_pkg::K_CANCELLED;
                            r_rs <= r_s; r_rid <= i_rd.id; r_mid <= '0;
                            r_rp <= i_rd.price; r_rq <= i_rd.qty; r_last <= 1'b0;
                            r_dp <= '{op: lobm_pkg::OP_REMOVE, side: r_s,
                                      idx: 5'(r_i), qty: '0};
                            r_ret <= S_CANCEL; r_state <= S_OUT;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_kind <= lobm_pkg::K_DONE;
                        r_rs <= 1'b0; r_rid <= '0; r_mid <= '0;
                        r_rp <= '0; r_rq <= '0; r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
